### sv/wept_pkg.sv
// Shared constants, register indexes and the pipeline stage type for the energy peak locator.
`default_nettype none

package wept_pkg;

    localparam int MAX_WINDOW  = 4096;
    localparam int HIST_AW     = $clog2(MAX_WINDOW);
    localparam int SAMPLE_BITS = 24;
    localparam int SQ_W        = 2 * SAMPLE_BITS - 1;
    localparam int ENERGY_W    = 58;
    localparam int MAX_SAMPLES = 16777216;
    localparam int FRAME_W     = $clog2(MAX_SAMPLES);
    localparam int CNT_W       = FRAME_W + 1;
    localparam int LEN_W       = 13;
    localparam int RATE_W      = 18;
    localparam int CFG_W       = 18;
    localparam int CFG_IDX_W   = 2;
    localparam int FRAC_W      = 16;
    localparam int TIME_W      = 28;
    localparam int PROD_W      = FRAME_W + LEN_W;
    localparam int DVD_W       = PROD_W + FRAC_W;
    localparam int DIV_CNT_W   = $clog2(DVD_W);

    localparam logic [LEN_W-1:0]  WINDOW_RESET = LEN_W'(960);
    localparam logic [LEN_W-1:0]  HOP_RESET    = LEN_W'(240);
    localparam logic [RATE_W-1:0] RATE_RESET   = RATE_W'(48000);
    localparam logic [TIME_W-1:0] ONE_SECOND   = TIME_W'(65536);

    localparam logic [CFG_IDX_W-1:0] REG_WINDOW = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_HOP    = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_RATE   = CFG_IDX_W'(2);

    // One sample moving from the front stage into the history/energy stage
    typedef struct packed {
        logic               valid;
        logic               proc;
        logic               sub;
        logic               last;
        logic               score;
        logic [FRAME_W-1:0] frame;
        logic [HIST_AW-1:0] rd_addr;
        logic [HIST_AW-1:0] wr_addr;
        logic [SQ_W-1:0]    sq;
    } t_stage;

endpackage

`default_nettype wire

### sv/wept_energy.sv
// Square history ring memory and sliding window energy sum.
`default_nettype none

module wept_energy import wept_pkg::*; (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire t_stage              i_stage,
    output t_stage                   o_stage,
    output logic [ENERGY_W-1:0]      o_energy
);

    logic [SQ_W-1:0]     r_hist [MAX_WINDOW];
    logic [SQ_W-1:0]     r_rdata;
    logic [SQ_W-1:0]     r_fwd_sq;
    logic                r_fwd;
    t_stage              r_stage;
    logic [ENERGY_W-1:0] r_energy;
    logic [ENERGY_W-1:0] n_energy;
    logic [SQ_W-1:0]     w_old;

    // write the square of the sample in stage two, read the leaving one in stage one
    always_ff @(posedge i_clk) begin
        if (r_stage.valid && r_stage.proc) begin
            r_hist[r_stage.wr_addr] <= r_stage.sq;
        end
        if (i_stage.valid && i_stage.proc && i_stage.sub) begin
            r_rdata <= r_hist[i_stage.rd_addr];
        end
        r_fwd_sq <= r_stage.sq;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage  <= '0;
            r_fwd    <= 1'b0;
            r_energy <= '0;
        end else begin
            r_stage <= i_stage;
            // bypass a write landing in the same cycle as the read of that slot
            r_fwd   <= r_stage.valid && r_stage.proc && (i_stage.rd_addr == r_stage.wr_addr);
            if (r_stage.valid) begin
                r_energy <= r_stage.last ? '0 : n_energy;
            end
        end
    end

    always_comb begin
        w_old    = r_fwd ? r_fwd_sq : r_rdata;
        n_energy = r_energy;
        if (r_stage.proc) begin
            if (r_stage.sub) begin
                n_energy = n_energy - ENERGY_W'(w_old);
            end
            n_energy = n_energy + ENERGY_W'(r_stage.sq);
        end
    end

    assign o_stage  = r_stage;
    assign o_energy = n_energy;

endmodule

`default_nettype wire

### sv/wept_div.sv
// Restoring divider, one quotient bit per cycle.
`default_nettype none

module wept_div import wept_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [DVD_W-1:0]  i_dividend,
    input  wire logic [RATE_W-1:0] i_divisor,
    output logic                   o_busy,
    output logic [DVD_W-1:0]       o_quot
);

    logic                 r_busy;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [RATE_W-1:0]    r_rem;
    logic [RATE_W-1:0]    r_dvs;
    logic [DVD_W-1:0]     r_quo;
    logic [RATE_W:0]      w_trial;
    logic                 w_ge;

    assign w_trial = {r_rem, r_quo[DVD_W-1]};
    assign w_ge    = w_trial >= {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= DIV_CNT_W'(DVD_W - 1);
        end else if (r_busy) begin
            if (r_cnt == '0) begin
                r_busy <= 1'b0;
            end
            r_cnt <= r_cnt - 1'b1;
        end
    end

    // shift dividend bits out the top, quotient bits in at the bottom
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_dvs <= i_divisor;
            r_quo <= i_dividend;
        end else if (r_busy) begin
            r_rem <= w_ge ? RATE_W'(w_trial - {1'b0, r_dvs}) : w_trial[RATE_W-1:0];
            r_quo <= {r_quo[DVD_W-2:0], w_ge};
        end
    end

    assign o_busy = r_busy;
    assign o_quot = r_quo;

endmodule

`default_nettype wire

### sv/windowed_energy_peak_time_core.sv
// Result path: after last is accepted, the best frame is captured, multiplied by hop, divided by rate, then registered.
// Throughput: one sample per cycle while a signal streams; after a last-marked sample the
// input stalls for the multiply and the serial divide, longer if a result waits.
// History ring: one 4096-entry memory, one read and one write per cycle, with bypass.
// Reset: synchronous, active low; restores register defaults and clears stream state.
// The ring needs no clearing pass: a slot is always written before it is read.
`default_nettype none

module windowed_energy_peak_time_core import wept_pkg::*; (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // configuration
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [CFG_W-1:0]     i_cfg_data,
    // sample channel
    input  wire logic                 i_valid,
    output logic                      o_ready,
    input  wire logic [SAMPLE_BITS-1:0] i_sample,
    input  wire logic                 i_last,
    // result channel
    output logic                      o_valid,
    input  wire logic                 i_ready,
    output logic [TIME_W-1:0]         o_peak_time_q16,
    output logic [FRAME_W-1:0]        o_peak_frame,
    output logic                      o_no_frame
);

    typedef enum logic [4:0] {
        S_RUN   = 5'b00001,
        S_LAST  = 5'b00010,
        S_MUL   = 5'b00100,
        S_START = 5'b01000,
        S_OUT   = 5'b10000
    } t_state;

    // configuration registers
    logic [LEN_W-1:0]  r_win;
    logic [LEN_W-1:0]  r_hop;
    logic [RATE_W-1:0] r_rate;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win  <= WINDOW_RESET;
            r_hop  <= HOP_RESET;
            r_rate <= RATE_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_WINDOW: r_win  <= i_cfg_data[LEN_W-1:0];
                REG_HOP:    r_hop  <= i_cfg_data[LEN_W-1:0];
                REG_RATE:   r_rate <= i_cfg_data[RATE_W-1:0];
                default:    ;
            endcase
        end
    end

    // Effective values: zero counts as one, window clamps at the ring depth
    logic [LEN_W-1:0]  w_win;
    logic [LEN_W-1:0]  w_hop;
    logic [RATE_W-1:0] w_rate;

    always_comb begin
        w_win = (r_win == '0) ? LEN_W'(1) : r_win;
        if (w_win > LEN_W'(MAX_WINDOW)) begin
            w_win = LEN_W'(MAX_WINDOW);
        end
        w_hop  = (r_hop == '0) ? LEN_W'(1) : r_hop;
        w_rate = (r_rate == '0) ? RATE_W'(1) : r_rate;
    end

    t_state r_state;
    logic   w_in_acc;

    assign o_ready  = (r_state == S_RUN);
    assign w_in_acc = i_valid && o_ready;

    // ------------------------------------------------------------------
    // Front stage: square the sample, count position, decide frame scoring
    // ------------------------------------------------------------------
    logic [CNT_W-1:0]       r_seen;
    logic [LEN_W-1:0]       r_countdown;
    logic [FRAME_W-1:0]     r_frame;
    logic [SAMPLE_BITS-1:0] w_mag;
    logic [2*SAMPLE_BITS-1:0] w_sq_full;
    logic                   w_proc;
    logic                   w_complete;
    t_stage                 w_s0;

    assign w_mag      = i_sample[SAMPLE_BITS-1] ? (~i_sample + 1'b1) : i_sample;
    assign w_sq_full  = w_mag * w_mag;
    assign w_proc     = r_seen < CNT_W'(MAX_SAMPLES);
    assign w_complete = (r_seen + 1'b1) >= CNT_W'(w_win);

    always_comb begin
        w_s0.valid   = w_in_acc;
        w_s0.proc    = w_proc;
        w_s0.sub     = r_seen >= CNT_W'(w_win);
        w_s0.last    = i_last;
        w_s0.score   = w_proc && w_complete && (r_countdown == '0);
        w_s0.frame   = r_frame;
        w_s0.rd_addr = r_seen[HIST_AW-1:0] - w_win[HIST_AW-1:0];
        w_s0.wr_addr = r_seen[HIST_AW-1:0];
        w_s0.sq      = w_sq_full[SQ_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen      <= '0;
            r_countdown <= '0;
            r_frame     <= '0;
        end else if (w_in_acc) begin
            if (i_last) begin
                // end of signal: start the next one from scratch
                r_seen      <= '0;
                r_countdown <= '0;
                r_frame     <= '0;
            end else if (w_proc) begin
                r_seen <= r_seen + 1'b1;
                if (w_complete) begin
                    if (r_countdown == '0) begin
                        r_countdown <= w_hop - 1'b1;
                        r_frame     <= r_frame + 1'b1;
                    end else begin
                        r_countdown <= r_countdown - 1'b1;
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // History ring and sliding energy
    // ------------------------------------------------------------------
    t_stage              w_s1;
    logic [ENERGY_W-1:0] w_energy;

    wept_energy u_energy (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_stage  (w_s0),
        .o_stage  (w_s1),
        .o_energy (w_energy)
    );

    // ------------------------------------------------------------------
    // Leader tracking: strictly greater energy wins, so ties keep the earlier frame
    // ------------------------------------------------------------------
    logic [ENERGY_W-1:0] r_best;
    logic [FRAME_W-1:0]  r_best_frame;
    logic                r_have;
    logic                w_take;
    logic [FRAME_W-1:0]  n_best_frame;
    logic                n_have;

    assign w_take       = w_s1.valid && w_s1.score && (!r_have || (w_energy > r_best));
    assign n_best_frame = w_take ? w_s1.frame : r_best_frame;
    assign n_have       = r_have || w_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_best       <= '0;
            r_best_frame <= '0;
            r_have       <= 1'b0;
        end else if (w_s1.valid) begin
            if (w_s1.last) begin
                r_best       <= '0;
                r_best_frame <= '0;
                r_have       <= 1'b0;
            end else if (w_take) begin
                r_best       <= w_energy;
                r_best_frame <= w_s1.frame;
                r_have       <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result: frame * hop * 2^16 / rate, saturated (one second if no frame scored), through the serial divider
    // ------------------------------------------------------------------
    logic [FRAME_W-1:0] r_res_frame;
    logic               r_res_have;
    logic [PROD_W-1:0]  r_prod;
    logic               w_div_start;
    logic               w_div_busy;
    logic [DVD_W-1:0]   w_quot;
    logic               w_out_load;
    logic [TIME_W-1:0]  w_time;

    assign w_div_start = (r_state == S_START);

    wept_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend ({r_prod, FRAC_W'(0)}),
        .i_divisor  (w_rate),
        .o_busy     (w_div_busy),
        .o_quot     (w_quot)
    );

    always_ff @(posedge i_clk) begin
        if (r_state == S_LAST) begin
            r_res_frame <= n_best_frame;
            r_res_have  <= n_have;
        end
        if (r_state == S_MUL) begin
            r_prod <= PROD_W'(r_res_frame) * PROD_W'(w_hop);
        end
    end

    always_comb begin
        if (!r_res_have) begin
            w_time = ONE_SECOND;
        end else if (w_quot[DVD_W-1:TIME_W] != '0) begin
            w_time = '1;
        end else begin
            w_time = w_quot[TIME_W-1:0];
        end
    end

    // Hold the result until taken; the divider's busy flag is low in S_OUT only when done
    assign w_out_load = (r_state == S_OUT) && !w_div_busy && (!o_valid || i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_RUN;
        end else begin
            case (r_state)
                S_RUN:   if (w_in_acc && i_last) r_state <= S_LAST;
                S_LAST:  r_state <= S_MUL;
                S_MUL:   r_state <= S_START;
                S_START: r_state <= S_OUT;
                S_OUT:   if (w_out_load) r_state <= S_RUN;
                default: r_state <= S_RUN;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (w_out_load) begin
            o_valid <= 1'b1;
        end else if (i_ready) begin
            o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            o_peak_time_q16 <= w_time;
            o_peak_frame    <= r_res_have ? r_res_frame : '0;
            o_no_frame      <= !r_res_have;
        end
    end

endmodule

`default_nettype wire
